// ===== rtl/way_bbox_hilbert_key_defines.svh =====
// assertion macros used by the port checker
`ifndef WAY_BBOX_HILBERT_KEY_DEFINES_SVH
`define WAY_BBOX_HILBERT_KEY_DEFINES_SVH

// checked only while out of reset
`define WHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define WHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/whk_pkg.sv =====
// types and constants shared by the path box and curve key modules
`timescale 1ns / 1ps

package whk_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int CNT_W   = 32;
    localparam int KEY_W   = 32;
    localparam int SCALE_W = 48;

    // centroid offset, twice the true offset
    localparam int SUM_W = LON_W + 3;
    localparam int OFF_W = SUM_W - 1;

    // offset x scale split into four partial products
    localparam int DL_W   = OFF_W / 2;
    localparam int DH_W   = OFF_W - DL_W;
    localparam int SL_W   = SCALE_W / 2;
    localparam int SH_W   = SCALE_W - SL_W;
    localparam int PP_W   = DH_W + SH_W;
    localparam int MID_W  = PP_W + (SL_W - DL_W) + 1;
    localparam int PROD_W = OFF_W + SCALE_W;
    localparam int QSHIFT = 33;
    localparam int Q_W    = PROD_W - QSHIFT;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 192;

    typedef enum logic [1:0] {
        REG_ORIGIN_LON = 2'd0,
        REG_ORIGIN_LAT = 2'd1,
        REG_LON_SCALE  = 2'd2,
        REG_LAT_SCALE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0]        number;
        logic signed [LAT_W-1:0] min_lat;
        logic signed [LAT_W-1:0] max_lat;
        logic signed [LON_W-1:0] min_lon;
        logic signed [LON_W-1:0] max_lon;
    } job_t;

endpackage

// ===== rtl/whk_box.sv =====
// running bounding box per path and path counter, launches one job per classified path
`timescale 1ns / 1ps

module whk_box
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [whk_pkg::LAT_W-1:0]   lat,
    input  logic signed [whk_pkg::LON_W-1:0]   lon,
    input  logic                               last,
    input  logic                               cls,
    input  logic                               job_ready,
    output logic                               job_valid,
    output whk_pkg::job_t                      job
);
    import whk_pkg::*;

    logic signed [LAT_W-1:0] min_lat_reg, max_lat_reg;
    logic signed [LAT_W-1:0] min_lat_next, max_lat_next;
    logic signed [LON_W-1:0] min_lon_reg, max_lon_reg;
    logic signed [LON_W-1:0] min_lon_next, max_lon_next;
    logic                    first_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    job_v_reg, job_v_next;
    job_t                    job_reg;
    logic                    accept;
    logic                    launch;

    assign in_ready = !job_v_reg || job_ready;
    assign accept   = in_valid && in_ready;
    assign launch   = accept && last && cls;

    always_comb
    begin
        if (first_reg)
        begin
            min_lat_next = lat;
            max_lat_next = lat;
            min_lon_next = lon;
            max_lon_next = lon;
        end
        else
        begin
            min_lat_next = (lat < min_lat_reg) ? lat : min_lat_reg;
            max_lat_next = (lat > max_lat_reg) ? lat : max_lat_reg;
            min_lon_next = (lon < min_lon_reg) ? lon : min_lon_reg;
            max_lon_next = (lon > max_lon_reg) ? lon : max_lon_reg;
        end
    end

    assign job_v_next = (job_v_reg && !job_ready) || launch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lat_reg <= '0;
            max_lat_reg <= '0;
            min_lon_reg <= '0;
            max_lon_reg <= '0;
            first_reg   <= 1'b1;
            count_reg   <= '0;
            job_v_reg   <= 1'b0;
        end
        else
        begin
            job_v_reg <= job_v_next;
            if (accept)
            begin
                min_lat_reg <= min_lat_next;
                max_lat_reg <= max_lat_next;
                min_lon_reg <= min_lon_next;
                max_lon_reg <= max_lon_next;
                first_reg   <= last;
                if (last)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            job_reg.number  <= count_reg;
            job_reg.min_lat <= min_lat_next;
            job_reg.max_lat <= max_lat_next;
            job_reg.min_lon <= min_lon_next;
            job_reg.max_lon <= max_lon_next;
        end
    end

    assign job_valid = job_v_reg;
    assign job       = job_reg;

endmodule

// ===== rtl/whk_scale.sv =====
// one axis: centroid offset, split multiply by the Q16.32 scale, grid saturation
`timescale 1ns / 1ps

module whk_scale #(
    parameter int GRID_BITS = 16
)
(
    input  logic                                 clk,
    input  logic [3:0]                           en,
    input  logic signed [whk_pkg::LON_W-1:0]     box_min,
    input  logic signed [whk_pkg::LON_W-1:0]     box_max,
    input  logic signed [whk_pkg::LON_W-1:0]     origin,
    input  logic [whk_pkg::SCALE_W-1:0]          scale,
    output logic [GRID_BITS-1:0]                 grid
);
    import whk_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic [OFF_W-1:0]        d_reg, d_next;
    logic [DL_W-1:0]         dl;
    logic [DH_W-1:0]         dh;
    logic [SL_W-1:0]         sl;
    logic [SH_W-1:0]         sh;
    logic [PP_W-1:0]         p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [PP_W-1:0]         p_ll_next, p_lh_next, p_hl_next, p_hh_next;
    logic [PP_W-1:0]         ll_reg, hh_reg;
    logic [MID_W-1:0]        mid_reg, mid_next;
    logic [PROD_W-1:0]       prod;
    logic [Q_W-1:0]          q;
    logic [GRID_BITS-1:0]    grid_reg, grid_next;

    // stage 1: twice the centroid offset, clamped at zero
    assign sum = {{(SUM_W-LON_W){box_min[LON_W-1]}}, box_min}
               + {{(SUM_W-LON_W){box_max[LON_W-1]}}, box_max}
               - {{(SUM_W-LON_W-1){origin[LON_W-1]}}, origin, 1'b0};
    assign d_next = (sum[SUM_W-1] || (sum == '0)) ? '0 : sum[OFF_W-1:0];

    // stage 2: four narrow partial products
    assign dl = d_reg[DL_W-1:0];
    assign dh = d_reg[OFF_W-1:DL_W];
    assign sl = scale[SL_W-1:0];
    assign sh = scale[SCALE_W-1:SL_W];
    assign p_ll_next = dl * sl;
    assign p_lh_next = dl * sh;
    assign p_hl_next = dh * sl;
    assign p_hh_next = dh * sh;

    // stage 3: middle terms aligned at weight 2^DL_W
    assign mid_next = (MID_W'(p_lh_reg) << (SL_W - DL_W)) + MID_W'(p_hl_reg);

    // stage 4: full product, drop 33 fraction bits, saturate to the grid
    assign prod = PROD_W'(ll_reg) + (PROD_W'(mid_reg) << DL_W)
                + (PROD_W'(hh_reg) << (DL_W + SL_W));
    assign q = prod[PROD_W-1:QSHIFT];
    assign grid_next = (|q[Q_W-1:GRID_BITS]) ? '1 : q[GRID_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg <= d_next;
        end
        if (en[1])
        begin
            p_ll_reg <= p_ll_next;
            p_lh_reg <= p_lh_next;
            p_hl_reg <= p_hl_next;
            p_hh_reg <= p_hh_next;
        end
        if (en[2])
        begin
            ll_reg  <= p_ll_reg;
            hh_reg  <= p_hh_reg;
            mid_reg <= mid_next;
        end
        if (en[3])
        begin
            grid_reg <= grid_next;
        end
    end

    assign grid = grid_reg;

endmodule

// ===== rtl/whk_cell.sv =====
// one level of the curve key: quadrant bits, reflect and swap, pass to the next cell
`timescale 1ns / 1ps

module whk_cell #(
    parameter int GRID_BITS = 16,
    parameter int LEVEL     = 15
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    output logic                          ready_in,
    input  logic [GRID_BITS-1:0]          x_in,
    input  logic [GRID_BITS-1:0]          y_in,
    input  logic [whk_pkg::KEY_W-1:0]     key_in,
    input  whk_pkg::job_t                 job_in,
    output logic                          valid_out,
    input  logic                          ready_out,
    output logic [GRID_BITS-1:0]          x_out,
    output logic [GRID_BITS-1:0]          y_out,
    output logic [whk_pkg::KEY_W-1:0]     key_out,
    output whk_pkg::job_t                 job_out
);
    import whk_pkg::*;

    logic                 v_reg;
    logic                 en;
    logic                 rx, ry;
    logic [GRID_BITS-1:0] x_next, y_next, xf, yf;
    logic [KEY_W-1:0]     key_next;
    logic [GRID_BITS-1:0] x_reg, y_reg;
    logic [KEY_W-1:0]     key_reg;
    job_t                 job_reg;

    assign en       = !v_reg || ready_out;
    assign ready_in = en;

    assign rx = x_in[LEVEL];
    assign ry = y_in[LEVEL];

    always_comb
    begin
        key_next = key_in;
        key_next[2*LEVEL +: 2] = {rx, rx ^ ry};
        xf = rx ? ~x_in : x_in;
        yf = rx ? ~y_in : y_in;
        if (!ry)
        begin
            x_next = yf;
            y_next = xf;
        end
        else
        begin
            x_next = x_in;
            y_next = y_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            key_reg <= key_next;
            job_reg <= job_in;
        end
    end

    assign valid_out = v_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign key_out   = key_reg;
    assign job_out   = job_reg;

endmodule

// ===== rtl/way_bbox_hilbert_key.sv =====
// top level: path bounding box, centroid grid mapping and Hilbert curve key
// throughput: one point per cycle; stages stall only when the result is not taken
// the path ends in a job register, four scaling stages, then GRID_BITS key cells
// reset: box, path counter and all valid bits clear at once, config registers read zero
`timescale 1ns / 1ps

module way_bbox_hilbert_key #(
    parameter int GRID_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_lat, point_lon
    input  logic [whk_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tlast,
    // classified
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // path_number, curve_key, box_min_lat, box_max_lat, box_min_lon, box_max_lon
    output logic [whk_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_addr,
    input  logic [whk_pkg::SCALE_W-1:0]         cfg_wdata
);
    import whk_pkg::*;

    localparam int NPRE = 4;

    logic signed [LON_W-1:0] origin_lon_reg;
    logic signed [LAT_W-1:0] origin_lat_reg;
    logic [SCALE_W-1:0]      lon_scale_reg;
    logic [SCALE_W-1:0]      lat_scale_reg;

    logic                    job_valid;
    job_t                    job;
    logic [NPRE-1:0]         pv_reg;
    logic [NPRE-1:0]         pv_in;
    logic [NPRE:0]           pen;
    job_t                    pjob_reg [NPRE];

    logic [GRID_BITS-1:0]    grid_x, grid_y;

    logic                    c_v   [GRID_BITS+1];
    logic                    c_rdy [GRID_BITS+1];
    logic [GRID_BITS-1:0]    c_x   [GRID_BITS+1];
    logic [GRID_BITS-1:0]    c_y   [GRID_BITS+1];
    logic [KEY_W-1:0]        c_key [GRID_BITS+1];
    job_t                    c_job [GRID_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_lon_reg <= '0;
            origin_lat_reg <= '0;
            lon_scale_reg  <= '0;
            lat_scale_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_ORIGIN_LON: origin_lon_reg <= cfg_wdata[LON_W-1:0];
                REG_ORIGIN_LAT: origin_lat_reg <= cfg_wdata[LAT_W-1:0];
                REG_LON_SCALE:  lon_scale_reg  <= cfg_wdata;
                REG_LAT_SCALE:  lat_scale_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    whk_box u_box
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .lat       (s_tdata[LAT_W-1:0]),
        .lon       (s_tdata[LAT_W+LON_W-1:LAT_W]),
        .last      (s_tlast),
        .cls       (s_tuser),
        .job_ready (pen[0]),
        .job_valid (job_valid),
        .job       (job)
    );

    // scaling stages: a stage loads when empty or when its content moves on
    always_comb
    begin
        pen[NPRE] = c_rdy[0];
        for (int k = NPRE - 1; k >= 0; k--)
        begin
            pen[k] = !pv_reg[k] || pen[k+1];
        end
        pv_in = {pv_reg[NPRE-2:0], job_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NPRE; k++)
            begin
                if (pen[k])
                begin
                    pv_reg[k] <= pv_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pen[0])
        begin
            pjob_reg[0] <= job;
        end
        for (int k = 1; k < NPRE; k++)
        begin
            if (pen[k])
            begin
                pjob_reg[k] <= pjob_reg[k-1];
            end
        end
    end

    whk_scale #(.GRID_BITS(GRID_BITS)) u_scale_lon
    (
        .clk     (clk),
        .en      (pen[NPRE-1:0]),
        .box_min (job.min_lon),
        .box_max (job.max_lon),
        .origin  (origin_lon_reg),
        .scale   (lon_scale_reg),
        .grid    (grid_x)
    );

    whk_scale #(.GRID_BITS(GRID_BITS)) u_scale_lat
    (
        .clk     (clk),
        .en      (pen[NPRE-1:0]),
        .box_min ({job.min_lat[LAT_W-1], job.min_lat}),
        .box_max ({job.max_lat[LAT_W-1], job.max_lat}),
        .origin  ({origin_lat_reg[LAT_W-1], origin_lat_reg}),
        .scale   (lat_scale_reg),
        .grid    (grid_y)
    );

    assign c_v[0]   = pv_reg[NPRE-1];
    assign c_x[0]   = grid_x;
    assign c_y[0]   = grid_y;
    assign c_key[0] = '0;
    assign c_job[0] = pjob_reg[NPRE-1];

    // one cell per grid bit, most significant level first
    for (genvar i = 0; i < GRID_BITS; i++)
    begin : g_cell
        whk_cell #(.GRID_BITS(GRID_BITS), .LEVEL(GRID_BITS - 1 - i)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (c_v[i]),
            .ready_in  (c_rdy[i]),
            .x_in      (c_x[i]),
            .y_in      (c_y[i]),
            .key_in    (c_key[i]),
            .job_in    (c_job[i]),
            .valid_out (c_v[i+1]),
            .ready_out (c_rdy[i+1]),
            .x_out     (c_x[i+1]),
            .y_out     (c_y[i+1]),
            .key_out   (c_key[i+1]),
            .job_out   (c_job[i+1])
        );
    end

    assign c_rdy[GRID_BITS] = m_tready;
    assign m_tvalid = c_v[GRID_BITS];
    assign m_tdata  = {2'b00,
                       c_job[GRID_BITS].max_lon,
                       c_job[GRID_BITS].min_lon,
                       c_job[GRID_BITS].max_lat,
                       c_job[GRID_BITS].min_lat,
                       c_key[GRID_BITS],
                       c_job[GRID_BITS].number};

endmodule

// ===== rtl/whk_checker.sv =====
// port checker for the path box and curve key block, bound to the top level
`timescale 1ns / 1ps
`include "way_bbox_hilbert_key_defines.svh"

module whk_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [whk_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import whk_pkg::*;

    logic signed [LAT_W-1:0] min_lat, max_lat;
    logic signed [LON_W-1:0] min_lon, max_lon;

    assign min_lat = m_tdata[94:64];
    assign max_lat = m_tdata[125:95];
    assign min_lon = m_tdata[157:126];
    assign max_lon = m_tdata[189:158];

    // no result while reset is held
    `WHK_ASSERT_ALWAYS(a_no_result_in_reset, ($past(!rst_n) && !rst_n |-> !m_tvalid), "result valid during reset")

    // the first edge after reset finds an empty pipeline
    `WHK_ASSERT(a_ready_after_reset, ($past(!rst_n) |-> s_tready), "input not ready after reset")

    // a stalled result holds
    `WHK_ASSERT(a_result_holds, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "stalled result changed")

    // the box is never inverted
    `WHK_ASSERT(a_box_ordered, (m_tvalid |-> (min_lat <= max_lat) && (min_lon <= max_lon)), "box minimum above maximum")

endmodule

bind way_bbox_hilbert_key whk_checker u_whk_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
